FILE: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial-division prime test: shared package
// Holds the operand width and the request and status bundles that pass
// between the sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Width of the signed integer under test.
  localparam int VALUE_WIDTH = 16;

  // Wide enough to count the magnitude bits of one operand.
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  // Start request to the remainder unit.
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } tdpt_div_req_t;

  // Status back from the remainder unit.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpt_div_sts_t;

endpackage

FILE: rtl/tdpt_rem_unit.sv
// ----------------------------------------------------------------------------
// Trial-division prime test: remainder unit
// Restoring bit-serial remainder, one dividend bit per cycle, with a single
// shared subtract and compare.
// ----------------------------------------------------------------------------
module tdpt_rem_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tdpt_pkg::tdpt_div_req_t req,
  output tdpt_pkg::tdpt_div_sts_t sts
);

  localparam int W = tdpt_pkg::VALUE_WIDTH;

  logic                        busy_r,  busy_nxt;
  logic                        done_r,  done_nxt;
  logic [tdpt_pkg::CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [W:0]                  rem_r,   rem_nxt;
  logic [W-2:0]                sh_r,    sh_nxt;
  logic [W-1:0]                dvs_r,   dvs_nxt;
  logic [W:0]                  trial;

  // Bring down the next dividend bit and subtract if the divisor fits.
  assign trial = {rem_r[W-1:0], sh_r[W-2]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tdpt_pkg::CNT_W'(W - 1);
      rem_nxt  = '0;
      sh_nxt   = req.dividend[W-2:0];
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
      end else begin
        rem_nxt = trial;
      end
      sh_nxt  = {sh_r[W-3:0], 1'b0};
      cnt_nxt = cnt_r - tdpt_pkg::CNT_W'(1);
      if (cnt_r == tdpt_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done     = done_r;
  assign sts.rem_zero = (rem_r == '0);

endmodule

FILE: rtl/trial_division_prime_test_unit.sv
// ----------------------------------------------------------------------------
// Trial-division prime test unit
// Tests one signed integer per transfer for primality and returns a flag.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                           Direction  Carries
//   in       in_valid, in_ready, in_value    sink       signed value to test
//   out      out_valid, out_ready, out_is_prime source  1 when value is prime
//
// A negative value, zero or one is settled in the sequencer without a trial
// division. Otherwise each trial divisor takes a bound check in the
// sequencer and then a pass through the bit-serial remainder unit. A prime
// near the top of the 16-bit range tries about 180 divisors.
// Reset clears the sequencer and the output register; none are pending after.
// A stall on the result channel holds the finished flag in the output
// register. The unit still takes the next value, but once that verdict is
// ready it waits in the sequencer with in_ready low until the register frees.
//
module trial_division_prime_test_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_prime
);

  localparam int W = tdpt_pkg::VALUE_WIDTH;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [W-1:0]            n_r,     n_nxt;      // value under test
  logic [W-1:0]            d_r,     d_nxt;      // current trial divisor
  logic [W:0]              sq_r,    sq_nxt;     // d_r squared, kept incrementally
  logic                    flag_r,  flag_nxt;   // verdict awaiting the output
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_flag_r,  out_flag_nxt;

  tdpt_pkg::tdpt_div_req_t div_req;
  tdpt_pkg::tdpt_div_sts_t div_sts;

  logic in_xfer;
  logic out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // The output register can take a new flag if empty or emptied this cycle.
  assign out_free = !out_valid_r || out_ready;

  assign div_req.start    = (state_r == ST_CHECK) && (sq_r <= {1'b0, n_r});
  assign div_req.dividend = n_r;
  assign div_req.divisor  = d_r;

  tdpt_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    flag_nxt  = flag_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          n_nxt  = in_value;
          d_nxt  = W'(2);
          sq_nxt = (W + 1)'(4);
          // Negative values and values below two are settled at once.
          if (in_value[W-1] || (in_value[W-1:1] == '0)) begin
            flag_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // Once the divisor squared passes the value, no factor is left.
        if (sq_r > {1'b0, n_r}) begin
          flag_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            flag_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            // (d + 1)^2 = d^2 + 2d + 1
            sq_nxt    = sq_r + {d_r, 1'b1};
            d_nxt     = d_r + W'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_flag_nxt  = flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_flag_r;

endmodule

FILE: rtl/tdpt_checker.sv
// ----------------------------------------------------------------------------
// Trial-division prime test: port checker
// Watches the top-level ports and flags sequences the unit must never show.
// ----------------------------------------------------------------------------
module tdpt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [tdpt_pkg::VALUE_WIDTH-1:0] in_value,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_is_prime
);

  localparam int W = tdpt_pkg::VALUE_WIDTH;

  // A stalled result keeps its flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_prime))
    else $error("result dropped or changed while stalled");

  // The unit works on one value at a time.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a transfer");

  // Negative values, zero and one are rejected quickly.
  a_trivial_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_value[W-1] || (in_value[W-1:1] == '0))
    && (!out_valid || out_ready)
    |-> ##2 (out_valid && !out_is_prime))
    else $error("trivial value not rejected in time");

  // A new result only appears while the unit is not taking input.
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_value     (in_value),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_is_prime (out_is_prime)
);
